[sv/rdsm_pkg.sv]
// shared types and constants for the dot-star matcher
// no dependencies; used by rdsm_cell and regex_dot_star_matcher_top
`default_nettype none

package rdsm_pkg;

    localparam int MAX_TOKENS = 32;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

    localparam logic [7:0] ANY_CHAR = 8'd46;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_END  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
        logic       starred;
        logic       first_token;
    } cmd_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } res_t;

    // per-cell control from the top level
    typedef struct packed {
        logic restart;
        logic step;
        logic write;
        logic in_use;
    } cell_ctl_t;

endpackage

`default_nettype wire

[sv/rdsm_cell.sv]
// one pattern position cell: holds token k and the active bit of position k+1
// depends on rdsm_pkg
`default_nettype none

module rdsm_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rdsm_pkg::cell_ctl_t ctl,
    input  wire logic [7:0]         symbol,
    input  wire logic               starred,
    input  wire logic               closed_in,
    input  wire logic               loop_in,
    output logic                    closed_out,
    output logic                    loop_out
);

    logic [7:0] char_reg;
    logic       rep_reg;
    logic       active_reg;
    logic       active_next;
    logic       hit;

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            char_reg <= symbol;
            rep_reg  <= starred;
        end
    end

    // position k is closed_in; a starred token lets it fall through to k+1
    assign closed_out = active_reg | (closed_in & rep_reg & ctl.in_use);

    assign hit = closed_in & ctl.in_use
                 & ((char_reg == rdsm_pkg::ANY_CHAR) | (char_reg == symbol));

    // a starred hit stays on position k, owned by the left neighbor
    assign loop_out = hit & rep_reg;

    always_comb
    begin
        active_next = active_reg;
        if (ctl.restart)
        begin
            active_next = 1'b0;
        end
        else if (ctl.step)
        begin
            active_next = (hit & ~rep_reg) | loop_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

[sv/regex_dot_star_matcher_top.sv]
// Whole-string matcher for patterns of literals, '.' and starred elements.
// Load the pattern as tokens (mode 0, first_token clears the old one), stream
// text characters (mode 1), then send an end item (mode 2) that returns one
// result and rearms for the next text. Items may follow each other in every
// cycle unless cmd_stall holds; the one-character step is a row of
// MAX_TOKENS cells whose star fall-through ripples through the row like a
// carry chain. The result sits in an output register, so input is taken while
// a result waits unless that result is stalled. Tokens past MAX_TOKENS are
// dropped and reported through pattern_overflow.
// depends on rdsm_pkg and rdsm_cell
`default_nettype none

module regex_dot_star_matcher_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire rdsm_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output rdsm_pkg::res_t     res
);

    localparam int N = rdsm_pkg::MAX_TOKENS;

    logic [rdsm_pkg::CNT_W-1:0] count_reg;
    logic [rdsm_pkg::CNT_W-1:0] count_next;
    logic [rdsm_pkg::CNT_W-1:0] base_count;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       pos0_reg;
    logic                       pos0_next;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    rdsm_pkg::res_t             res_reg;
    rdsm_pkg::res_t             res_next;

    logic                       accept;
    logic                       do_load;
    logic                       do_text;
    logic                       do_end;
    logic                       full;
    logic                       fin;

    logic [N:0]                 closed;
    logic [N:0]                 loop;
    rdsm_pkg::cell_ctl_t        ctl [N];

    assign cmd_stall = res_valid_reg & res_stall;
    assign accept    = cmd_valid & ~cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        do_load = 1'b0;
        do_text = 1'b0;
        do_end  = 1'b0;
        unique case (rdsm_pkg::mode_t'(cmd.mode))
            rdsm_pkg::MODE_LOAD: do_load = accept;
            rdsm_pkg::MODE_TEXT: do_text = accept;
            rdsm_pkg::MODE_END:  do_end  = accept;
            default: ;
        endcase
    end

    assign base_count = cmd.first_token ? '0 : count_reg;
    assign full       = (base_count == rdsm_pkg::CNT_W'(N));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (do_load)
        begin
            count_next = full ? base_count : base_count + 1'b1;
            ovf_next   = full | (ovf_reg & ~cmd.first_token);
        end
    end

    assign closed[0] = pos0_reg;
    assign loop[N]   = 1'b0;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        always_comb
        begin
            ctl[k].restart = do_load | do_end;
            ctl[k].step    = do_text;
            ctl[k].write   = do_load & ~full
                             & (base_count == rdsm_pkg::CNT_W'(k));
            ctl[k].in_use  = (count_reg > rdsm_pkg::CNT_W'(k));
        end

        rdsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[k]),
            .symbol     (cmd.symbol),
            .starred    (cmd.starred),
            .closed_in  (closed[k]),
            .loop_in    (loop[k+1]),
            .closed_out (closed[k+1]),
            .loop_out   (loop[k])
        );
    end

    // closed set at the end position of the pattern
    always_comb
    begin
        fin = 1'b0;
        for (int k = 0; k <= N; k++)
        begin
            if (count_reg == rdsm_pkg::CNT_W'(k))
            begin
                fin = closed[k];
            end
        end
    end

    always_comb
    begin
        pos0_next = pos0_reg;
        if (do_load | do_end)
        begin
            pos0_next = 1'b1;
        end
        else if (do_text)
        begin
            pos0_next = loop[0];
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg & res_stall;
        res_next       = res_reg;
        if (do_end)
        begin
            res_valid_next            = 1'b1;
            res_next.matched          = fin;
            res_next.pattern_overflow = ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pos0_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pos0_reg      <= pos0_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

[sim/tb_regex_dot_star_matcher_top.sv]
// testbench for regex_dot_star_matcher_top: random and directed token, text and end items,
// a built-in position-set predictor, and in-order checking of every verdict item
// depends on rdsm_pkg and regex_dot_star_matcher_top

module tb_regex_dot_star_matcher_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS    = 700;
    localparam int CALM_TAIL      = 60;
    localparam int HOLD_AFTER     = 30;
    localparam int HOLD_LEN       = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [7:0] STAR_CHAR = 8'd42;
    localparam logic [7:0] CH_A      = 8'd97;
    localparam logic [7:0] CH_B      = 8'd98;

    // only position zero active
    localparam logic [rdsm_pkg::MAX_TOKENS:0] START_SET = {{rdsm_pkg::MAX_TOKENS{1'b0}}, 1'b1};

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic res_stall = 1'b0;
    rdsm_pkg::cmd_t cmd = '0;
    logic cmd_stall;
    logic res_valid;
    rdsm_pkg::res_t res;

    regex_dot_star_matcher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    rdsm_pkg::cmd_t pending_cmds[$];
    rdsm_pkg::res_t expected_verdicts[$];
    int   queued_items = 0;
    int   fails        = 0;

    // predictor state
    logic [7:0]                    pat_chr[rdsm_pkg::MAX_TOKENS];
    logic                          pat_rep[rdsm_pkg::MAX_TOKENS];
    int                            pat_len     = 0;
    logic [rdsm_pkg::MAX_TOKENS:0] live        = START_SET;
    logic                          pat_dropped = 1'b0;

    // pattern mirror used only to build matching texts
    logic [7:0] gen_chr[$];
    logic       gen_rep[$];

    initial begin
        forever #5 clk = ~clk;
    end

    // positions reachable by skipping starred tokens
    function automatic logic [rdsm_pkg::MAX_TOKENS:0] skip_starred(
        logic [rdsm_pkg::MAX_TOKENS:0] s);
        for (int k = 0; k < pat_len; k++)
            if (s[k] && pat_rep[k])
                s[k + 1] = 1'b1;
        return s;
    endfunction

    function automatic void track_matcher(rdsm_pkg::cmd_t c);
        logic [rdsm_pkg::MAX_TOKENS:0] cur;
        logic [rdsm_pkg::MAX_TOKENS:0] nxt;
        rdsm_pkg::res_t v;
        case (rdsm_pkg::mode_t'(c.mode))
            rdsm_pkg::MODE_LOAD:
            begin
                if (c.first_token)
                begin
                    pat_len     = 0;
                    pat_dropped = 1'b0;
                end
                if (pat_len < rdsm_pkg::MAX_TOKENS)
                begin
                    pat_chr[pat_len] = c.symbol;
                    pat_rep[pat_len] = c.starred;
                    pat_len++;
                end
                else
                    pat_dropped = 1'b1;
                live = START_SET;
            end
            rdsm_pkg::MODE_TEXT:
            begin
                cur = skip_starred(live);
                nxt = '0;
                for (int k = 0; k < pat_len; k++)
                    if (cur[k] && (pat_chr[k] == rdsm_pkg::ANY_CHAR
                                   || pat_chr[k] == c.symbol))
                    begin
                        if (pat_rep[k])
                            nxt[k] = 1'b1;
                        else
                            nxt[k + 1] = 1'b1;
                    end
                live = nxt;
            end
            rdsm_pkg::MODE_END:
            begin
                cur                = skip_starred(live);
                v.matched          = cur[pat_len];
                v.pattern_overflow = pat_dropped;
                expected_verdicts.push_back(v);
                live = START_SET;
            end
            default:
                ;
        endcase
    endfunction

    function automatic void queue_cmd(rdsm_pkg::mode_t m, logic [7:0] sym, logic st, logic ft);
        rdsm_pkg::cmd_t c;
        c.mode        = m;
        c.symbol      = sym;
        c.starred     = st;
        c.first_token = ft;
        pending_cmds.push_back(c);
        if (m != rdsm_pkg::MODE_NONE)
            queued_items++;
    endfunction

    // mostly a small alphabet so that texts hit the pattern often
    function automatic logic [7:0] pick_char(bit allow_any);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (r <= 3)
            return allow_any ? rdsm_pkg::ANY_CHAR : CH_A;
        return 8'(CH_A + $urandom_range(0, 2));
    endfunction

    task automatic build_directed();
        queue_cmd(rdsm_pkg::MODE_END, 8'd0, 1'b0, 1'b0);            // empty pattern, empty text
        queue_cmd(rdsm_pkg::MODE_LOAD, CH_A, 1'b1, 1'b1);           // a*
        repeat (3) queue_cmd(rdsm_pkg::MODE_TEXT, CH_A, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_END, 8'd0, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_END, 8'hff, 1'b1, 1'b1);           // star taken zero times
        queue_cmd(rdsm_pkg::MODE_LOAD, rdsm_pkg::ANY_CHAR, 1'b0, 1'b1); // .b
        queue_cmd(rdsm_pkg::MODE_LOAD, CH_B, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_TEXT, rdsm_pkg::ANY_CHAR, 1'b0, 1'b0); // dot as a text char
        queue_cmd(rdsm_pkg::MODE_TEXT, CH_B, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_END, 8'd0, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_LOAD, STAR_CHAR, 1'b0, 1'b1);      // star char is a literal
        queue_cmd(rdsm_pkg::MODE_TEXT, STAR_CHAR, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_END, 8'd0, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_LOAD, 8'd0, 1'b0, 1'b1);           // extreme symbols
        queue_cmd(rdsm_pkg::MODE_LOAD, 8'hff, 1'b1, 1'b0);
        queue_cmd(rdsm_pkg::MODE_TEXT, 8'd0, 1'b1, 1'b1);
        queue_cmd(rdsm_pkg::MODE_TEXT, 8'hff, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_NONE, 8'hff, 1'b1, 1'b1);          // ignored mode
        queue_cmd(rdsm_pkg::MODE_TEXT, 8'hff, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_END, 8'd0, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_TEXT, 8'd0, 1'b0, 1'b0);
        queue_cmd(rdsm_pkg::MODE_LOAD, rdsm_pkg::ANY_CHAR, 1'b1, 1'b0); // load restarts text
        queue_cmd(rdsm_pkg::MODE_END, 8'd0, 1'b0, 1'b0);
    endtask

    task automatic build_random();
        bit         fresh_needed;
        int         ntok;
        int         reps;
        logic [7:0] ch;
        logic       st;
        fresh_needed = 1'b1;
        while (queued_items < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                // noise
                repeat ($urandom_range(1, 4))
                    queue_cmd(rdsm_pkg::mode_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                fresh_needed = 1'b1;
            end
            else
            begin
                if (fresh_needed || $urandom_range(0, 2) == 0)
                begin
                    ntok = ($urandom_range(0, 14) == 0) ?
                           $urandom_range(rdsm_pkg::MAX_TOKENS + 1, rdsm_pkg::MAX_TOKENS + 4)
                           : $urandom_range(1, 6);
                    gen_chr.delete();
                    gen_rep.delete();
                    for (int k = 0; k < ntok; k++)
                    begin
                        ch = pick_char(1'b1);
                        st = ($urandom_range(0, 2) == 0);
                        queue_cmd(rdsm_pkg::MODE_LOAD, ch, st, k == 0);
                        if (k < rdsm_pkg::MAX_TOKENS)
                        begin
                            gen_chr.push_back(ch);
                            gen_rep.push_back(st);
                        end
                    end
                    fresh_needed = 1'b0;
                end
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1))
                    begin
                        // text built to match, sometimes spoiled by a trailing char
                        foreach (gen_chr[k])
                        begin
                            reps = gen_rep[k] ? $urandom_range(0, 3) : 1;
                            repeat (reps)
                                queue_cmd(rdsm_pkg::MODE_TEXT,
                                          (gen_chr[k] == rdsm_pkg::ANY_CHAR) ?
                                          pick_char(1'b0) : gen_chr[k],
                                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        end
                        if ($urandom_range(0, 5) == 0)
                            queue_cmd(rdsm_pkg::MODE_TEXT, pick_char(1'b1), 1'b0, 1'b0);
                    end
                    else
                        repeat ($urandom_range(0, 6))
                            queue_cmd(rdsm_pkg::MODE_TEXT, pick_char(1'b1),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 19) == 0)
                    begin
                        queue_cmd(rdsm_pkg::MODE_LOAD, pick_char(1'b1),
                                  1'($urandom_range(0, 1)), 1'b0);
                        fresh_needed = 1'b1;
                    end
                    queue_cmd(rdsm_pkg::MODE_END, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // driver
    int send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                track_matcher(cmd);
            if (!cmd_valid || !cmd_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    if (pending_cmds.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 18);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // monitor and result-side stall
    int   stall_left = 0;
    int   hold_left  = 0;
    int   seen       = 0;
    bit   hold_done  = 1'b0;
    rdsm_pkg::res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                seen++;
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected verdict item: matched=%0d pattern_overflow=%0d",
                           res.matched, res.pattern_overflow);
                    fails++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (res.matched !== want.matched)
                    begin
                        $error("matched: expected %0d, got %0d", want.matched, res.matched);
                        fails++;
                    end
                    if (res.pattern_overflow !== want.pattern_overflow)
                    begin
                        $error("pattern_overflow: expected %0d, got %0d",
                               want.pattern_overflow, res.pattern_overflow);
                        fails++;
                    end
                end
            end
            // one long hold-off so the output backs up into the input
            if (!hold_done && seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (pending_cmds.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no item moving on either side
    int quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT)
                begin
                    $display("regex_dot_star_matcher_top verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_cmds.size() > 0 || cmd_valid)
            @(posedge clk);
        while (expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && expected_verdicts.size() == 0)
            $display("regex_dot_star_matcher_top verification clean");
        else
            $display("regex_dot_star_matcher_top verification failed");
        $finish;
    end

endmodule
